/* rtl/dvsd_pkg.sv */
`timescale 1ns / 1ps

package dvsd_pkg;

    localparam int HIST_AW    = 16;
    localparam int HIST_DEPTH = 1 << HIST_AW;

    localparam int MAX_ITEMS  = 128;
    localparam int ITEM_CW    = $clog2(MAX_ITEMS + 1);
    localparam int LANES      = 4;
    localparam int GRP_MAX    = MAX_ITEMS / LANES;
    localparam int GRP_AW     = $clog2(GRP_MAX);
    localparam int GRP_CW     = $clog2(GRP_MAX + 1);

    localparam int STORE_W    = 24;
    localparam int CNT_W      = 5;
    localparam int STRIP_W    = 17;

    localparam logic [CNT_W-1:0] IL_BITS    = 5'd2;
    localparam logic [CNT_W-1:0] STRIP_BITS = 5'd16;
    localparam logic [CNT_W-1:0] COUNT_BITS = 5'd7;
    localparam logic [CNT_W-1:0] WCODE_BITS = 5'd3;
    localparam logic [CNT_W-1:0] STORE_MAX  = 5'd24;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_STRIP,
        PH_COUNT,
        PH_WIDTH,
        PH_ITEMS,
        PH_DONE
    } dvsd_phase_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_STEP,
        CS_ITEM
    } dvsd_core_state_t;

    typedef enum logic [1:0] {
        BS_FILL,
        BS_READ,
        BS_LOAD
    } dvsd_buf_state_t;

    typedef struct packed {
        logic       push;
        logic [7:0] value;
        logic       finish;
        logic       done;
        logic [1:0] inter;
    } dvsd_push_t;

endpackage

/* rtl/dvsd_if.sv */
`timescale 1ns / 1ps

interface dvsd_in_if;
    logic       valid;
    logic       ready;
    logic       start_of_stream;
    logic [7:0] data_byte;

    modport source (output valid, output start_of_stream, output data_byte, input ready);
    modport sink (input valid, input start_of_stream, input data_byte, output ready);
endinterface

interface dvsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] lane_byte_0;
    logic [7:0] lane_byte_1;
    logic [7:0] lane_byte_2;
    logic [7:0] lane_byte_3;
    logic [2:0] valid_bytes;
    logic       final_for_input;
    logic       stream_done;
    logic [2:0] interleave_factor;

    modport source (
        output valid, output lane_byte_0, output lane_byte_1, output lane_byte_2,
        output lane_byte_3, output valid_bytes, output final_for_input,
        output stream_done, output interleave_factor, input ready
    );
    modport sink (
        input valid, input lane_byte_0, input lane_byte_1, input lane_byte_2,
        input lane_byte_3, input valid_bytes, input final_for_input,
        input stream_done, input interleave_factor, output ready
    );
endinterface

/* rtl/dvsd_core.sv */
`timescale 1ns / 1ps

module dvsd_core import dvsd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    dvsd_in_if.sink      stream,
    input  logic         busy,
    output dvsd_push_t   push_out
);

    dvsd_core_state_t state_reg, state_next;
    dvsd_phase_t      phase_reg, phase_next, phase_b;

    logic [STORE_W-1:0] store_reg, store_next, store_b;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, cnt_b;
    logic [1:0]         inter_reg, inter_next;
    logic [STRIP_W-1:0] strip_reg, strip_next;
    logic [6:0]         run_reg, run_next;
    logic [3:0]         width_reg, width_next;
    logic [7:0]         val_reg, val_next;
    logic [STRIP_W-1:0] made_reg, made_next;
    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic [7:0]         prev_far_reg, prev_far_next;
    logic [ITEM_CW-1:0] n_reg, n_next;

    logic [7:0] hist_mem [HIST_DEPTH];
    logic [7:0] far_reg;
    logic [HIST_AW-1:0] rd_addr;
    logic hist_re;
    logic hist_we;

    logic               accept;
    logic [CNT_W-1:0]   take_n;
    logic               have_bits;
    logic [CNT_W-1:0]   cnt_after;
    logic [STORE_W-1:0] take_v;
    logic [STORE_W-1:0] store_after;
    logic               step_hdr;
    logic               step_run_end;
    logic               step_item;
    logic               step_stall;
    logic [CNT_W:0]     cnt_sum;

    logic [7:0] bias;
    logic [7:0] acc_base;
    logic [7:0] acc;
    logic       use_hist;

    function automatic logic [STORE_W-1:0] low_mask(input logic [CNT_W-1:0] n);
        low_mask = (STORE_W'(1) << n) - STORE_W'(1);
    endfunction

    assign accept = stream.valid && stream.ready;

    always_comb
    begin
        case (phase_reg)
            PH_SKIP:  take_n = IL_BITS;
            PH_STRIP: take_n = STRIP_BITS;
            PH_COUNT: take_n = COUNT_BITS;
            PH_WIDTH: take_n = WCODE_BITS;
            PH_ITEMS: take_n = {1'b0, width_reg};
            default:  take_n = '0;
        endcase
    end

    assign have_bits   = cnt_reg >= take_n;
    assign cnt_after   = cnt_reg - take_n;
    assign take_v      = (store_reg >> cnt_after) & low_mask(take_n);
    assign store_after = store_reg & low_mask(cnt_after);

    assign step_hdr = have_bits && ((phase_reg == PH_SKIP) || (phase_reg == PH_STRIP)
                      || (phase_reg == PH_COUNT) || (phase_reg == PH_WIDTH));
    assign step_run_end = (phase_reg == PH_ITEMS) && (run_reg == 7'd0);
    assign step_item    = (phase_reg == PH_ITEMS) && (run_reg != 7'd0) && have_bits
                          && (n_reg < ITEM_CW'(MAX_ITEMS));
    assign step_stall   = !step_hdr && !step_run_end && !step_item;

    assign rd_addr  = wp_reg - strip_reg[HIST_AW-1:0];
    assign bias     = (width_reg == 4'd0) ? 8'd0 : (8'd1 << (width_reg - 4'd1));
    assign acc_base = val_reg + take_v[7:0] - bias;
    assign use_hist = (strip_reg != STRIP_W'(1)) && (made_reg > strip_reg);
    assign acc      = use_hist ? (acc_base + far_reg - prev_far_reg) : acc_base;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                    state_next = CS_STEP;
            end
            CS_STEP:
            begin
                if (step_item)
                    state_next = CS_ITEM;
                else if (step_stall)
                    state_next = CS_IDLE;
            end
            CS_ITEM:
            begin
                state_next = CS_STEP;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stream.ready    = (state_reg == CS_IDLE) && !busy;
        hist_re         = (state_reg == CS_STEP) && step_item;
        hist_we         = (state_reg == CS_ITEM);
        push_out.push   = (state_reg == CS_ITEM);
        push_out.value  = acc;
        push_out.finish = (state_reg == CS_STEP) && step_stall;
        push_out.done   = (phase_reg == PH_DONE);
        push_out.inter  = inter_reg;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        store_next    = store_reg;
        cnt_next      = cnt_reg;
        inter_next    = inter_reg;
        strip_next    = strip_reg;
        run_next      = run_reg;
        width_next    = width_reg;
        val_next      = val_reg;
        made_next     = made_reg;
        wp_next       = wp_reg;
        prev_far_next = prev_far_reg;
        n_next        = n_reg;
        phase_b       = phase_reg;
        store_b       = store_reg;
        cnt_b         = cnt_reg;
        cnt_sum       = '0;
        case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                begin
                    if (stream.start_of_stream)
                    begin
                        phase_b       = PH_SKIP;
                        store_b       = '0;
                        cnt_b         = '0;
                        inter_next    = '0;
                        strip_next    = STRIP_W'(1);
                        run_next      = '0;
                        width_next    = '0;
                        val_next      = '0;
                        made_next     = '0;
                        wp_next       = '0;
                        prev_far_next = '0;
                    end
                    phase_next = phase_b;
                    store_next = store_b;
                    cnt_next   = cnt_b;
                    if (phase_b != PH_DONE)
                    begin
                        store_next = {store_b[STORE_W-9:0], stream.data_byte};
                        cnt_sum    = {1'b0, cnt_b} + 6'd8;
                        cnt_next   = (cnt_sum > {1'b0, STORE_MAX}) ? STORE_MAX
                                                                   : cnt_sum[CNT_W-1:0];
                    end
                    n_next = '0;
                end
            end
            CS_STEP:
            begin
                if (step_hdr)
                begin
                    cnt_next   = cnt_after;
                    store_next = store_after;
                    case (phase_reg)
                        PH_SKIP:
                        begin
                            inter_next = take_v[1:0];
                            phase_next = PH_STRIP;
                        end
                        PH_STRIP:
                        begin
                            strip_next = {1'b0, take_v[15:0]} + STRIP_W'(1);
                            phase_next = PH_COUNT;
                        end
                        PH_COUNT:
                        begin
                            run_next   = take_v[6:0];
                            phase_next = (take_v[6:0] == 7'd0) ? PH_DONE : PH_WIDTH;
                        end
                        PH_WIDTH:
                        begin
                            width_next = (take_v[2:0] == 3'd0) ? 4'd0
                                                               : ({1'b0, take_v[2:0]} + 4'd1);
                            phase_next = PH_ITEMS;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                else if (step_run_end)
                begin
                    phase_next = PH_COUNT;
                end
            end
            CS_ITEM:
            begin
                cnt_next      = cnt_after;
                store_next    = store_after;
                val_next      = acc;
                prev_far_next = far_reg;
                wp_next       = wp_reg + HIST_AW'(1);
                run_next      = run_reg - 7'd1;
                n_next        = n_reg + ITEM_CW'(1);
                if (made_reg <= strip_reg)
                    made_next = made_reg + STRIP_W'(1);
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CS_IDLE;
            phase_reg    <= PH_SKIP;
            store_reg    <= '0;
            cnt_reg      <= '0;
            inter_reg    <= '0;
            strip_reg    <= STRIP_W'(1);
            run_reg      <= '0;
            width_reg    <= '0;
            val_reg      <= '0;
            made_reg     <= '0;
            wp_reg       <= '0;
            prev_far_reg <= '0;
            n_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            store_reg    <= store_next;
            cnt_reg      <= cnt_next;
            inter_reg    <= inter_next;
            strip_reg    <= strip_next;
            run_reg      <= run_next;
            width_reg    <= width_next;
            val_reg      <= val_next;
            made_reg     <= made_next;
            wp_reg       <= wp_next;
            prev_far_reg <= prev_far_next;
            n_reg        <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[wp_reg] <= acc;
        if (hist_re)
            far_reg <= hist_mem[rd_addr];
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= STORE_MAX)
        else $error("bit count exceeds the bit store");

    a_item_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= ITEM_CW'(MAX_ITEMS))
        else $error("too many decoded bytes for one beat");

    a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        hist_re |=> hist_we && push_out.push)
        else $error("history read not followed by its write back");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !busy && (state_reg == CS_IDLE))
        else $error("beat taken while results are still being sent");
`endif

endmodule

/* rtl/dvsd_result_buf.sv */
`timescale 1ns / 1ps

module dvsd_result_buf import dvsd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  dvsd_push_t  push_in,
    output logic        busy,
    dvsd_out_if.source  result
);

    localparam int WORD_W = 3 + 8 * LANES;

    dvsd_buf_state_t state_reg, state_next;

    logic [7:0]        lane_reg [LANES];
    logic [7:0]        lane_next [LANES];
    logic [1:0]        lcnt_reg, lcnt_next;
    logic [GRP_CW-1:0] grp_reg, grp_next;
    logic [GRP_CW-1:0] total_reg, total_next;
    logic [GRP_CW-1:0] k_reg, k_next;

    logic [WORD_W-1:0] grp_mem [GRP_MAX];
    logic [WORD_W-1:0] rdata_reg;
    logic              wr_en;
    logic [WORD_W-1:0] wr_word;
    logic              rd_en;
    logic              load;
    logic              last;

    logic       oval_reg;
    logic [7:0] ob0_reg, ob1_reg, ob2_reg, ob3_reg;
    logic [2:0] ovb_reg;
    logic       ofin_reg;
    logic       odone_reg;
    logic [2:0] oil_reg;

    assign last = (k_reg + GRP_CW'(1)) == total_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_FILL:
            begin
                if (push_in.finish)
                    state_next = BS_READ;
            end
            BS_READ:
            begin
                state_next = BS_LOAD;
            end
            BS_LOAD:
            begin
                if (load)
                    state_next = last ? BS_FILL : BS_READ;
            end
            default:
            begin
                state_next = BS_FILL;
            end
        endcase
    end

    always_comb
    begin
        busy  = (state_reg != BS_FILL);
        rd_en = (state_reg == BS_READ);
        load  = (state_reg == BS_LOAD) && (!oval_reg || result.ready);
    end

    always_comb
    begin
        lane_next  = lane_reg;
        lcnt_next  = lcnt_reg;
        grp_next   = grp_reg;
        total_next = total_reg;
        k_next     = k_reg;
        wr_en      = 1'b0;
        wr_word    = {1'b0, lcnt_reg, lane_reg[3], lane_reg[2], lane_reg[1], lane_reg[0]};
        if (push_in.push)
        begin
            if (lcnt_reg == 2'd3)
            begin
                wr_en     = 1'b1;
                wr_word   = {3'd4, push_in.value, lane_reg[2], lane_reg[1], lane_reg[0]};
                grp_next  = grp_reg + GRP_CW'(1);
                lcnt_next = 2'd0;
                for (int i = 0; i < LANES; i++)
                    lane_next[i] = 8'd0;
            end
            else
            begin
                lane_next[lcnt_reg] = push_in.value;
                lcnt_next           = lcnt_reg + 2'd1;
            end
        end
        else if (push_in.finish)
        begin
            wr_en      = (lcnt_reg != 2'd0) || (grp_reg == '0);
            total_next = grp_reg + (wr_en ? GRP_CW'(1) : GRP_CW'(0));
            grp_next   = '0;
            lcnt_next  = 2'd0;
            k_next     = '0;
            for (int i = 0; i < LANES; i++)
                lane_next[i] = 8'd0;
        end
        if (load)
            k_next = k_reg + GRP_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_FILL;
            lcnt_reg  <= '0;
            grp_reg   <= '0;
            total_reg <= '0;
            k_reg     <= '0;
            oval_reg  <= 1'b0;
            for (int i = 0; i < LANES; i++)
                lane_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            lcnt_reg  <= lcnt_next;
            grp_reg   <= grp_next;
            total_reg <= total_next;
            k_reg     <= k_next;
            lane_reg  <= lane_next;
            if (load)
                oval_reg <= 1'b1;
            else if (result.ready)
                oval_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            grp_mem[grp_reg[GRP_AW-1:0]] <= wr_word;
        if (rd_en)
            rdata_reg <= grp_mem[k_reg[GRP_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ob0_reg   <= rdata_reg[7:0];
            ob1_reg   <= rdata_reg[15:8];
            ob2_reg   <= rdata_reg[23:16];
            ob3_reg   <= rdata_reg[31:24];
            ovb_reg   <= rdata_reg[WORD_W-1:32];
            ofin_reg  <= last;
            odone_reg <= push_in.done;
            oil_reg   <= {1'b0, push_in.inter} + 3'd1;
        end
    end

    assign result.valid             = oval_reg;
    assign result.lane_byte_0       = ob0_reg;
    assign result.lane_byte_1       = ob1_reg;
    assign result.lane_byte_2       = ob2_reg;
    assign result.lane_byte_3       = ob3_reg;
    assign result.valid_bytes       = ovb_reg;
    assign result.final_for_input   = ofin_reg;
    assign result.stream_done       = odone_reg;
    assign result.interleave_factor = oil_reg;

`ifndef ASSERT_OFF
    a_push_while_filling: assert property (@(posedge clk) disable iff (!rst_n)
        (push_in.push || push_in.finish) |-> (state_reg == BS_FILL))
        else $error("decoded byte arrived while results are being sent");

    a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
        grp_reg <= GRP_CW'(GRP_MAX))
        else $error("group count overflow");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BS_FILL) |-> (k_reg < total_reg))
        else $error("result index past the last group");
`endif

endmodule

/* rtl/differential_volume_stream_decoder.sv */
// Decode order: a beat is taken, then each decode step (header field, run count,
// width code, end of run) follows in turn; each decoded byte takes a history read, then an
// update and write back; each result takes a group buffer read, then an output load that waits for the output.
// Flow: a new beat is taken only after every result of the previous beat has been loaded.
// Reset: control state clears asynchronously; the history memory is not cleared.
`timescale 1ns / 1ps

module differential_volume_stream_decoder import dvsd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    dvsd_in_if.sink    stream,
    dvsd_out_if.source result
);

    dvsd_push_t push;
    logic       busy;

    dvsd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream),
        .busy     (busy),
        .push_out (push)
    );

    dvsd_result_buf u_result_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push),
        .busy    (busy),
        .result  (result)
    );

endmodule
